// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle check on clk_i, off while rst_ni is low.
`define TCCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define TCCW_ASSERT_IMPL(label, ante, cons, msg) \
  `TCCW_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
  `TCCW_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- src/tccw_pkg.sv -----
package tccw_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [OP_W-1:0] OPC_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OPC_BKSP  = 2'd1;
  localparam logic [OP_W-1:0] OPC_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OPC_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] BLINK_BIT       = 8'h80;
  localparam logic [ATTR_W-1:0] NORMAL_ATTR_RST = 8'd15;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PLAIN,
    ST_LINE,
    ST_SCROLL,
    ST_SCDRAIN,
    ST_FIN,
    ST_CLEAR,
    ST_BS_CHK,
    ST_RDW,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [IDX_W-1:0]  cursor_pos;
    logic              scrolled;
  } result_t;

endpackage

// ----- src/tccw_in_if.sv -----
interface tccw_in_if import tccw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] char_attr;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, opcode, char_code, char_attr, read_index, input ready);
  modport sink (input valid, opcode, char_code, char_attr, read_index, output ready);
endinterface

// ----- src/tccw_out_if.sv -----
interface tccw_out_if import tccw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [IDX_W-1:0]  cursor_pos;
  logic              scrolled;

  modport source (output valid, cell_value, cursor_pos, scrolled, input ready);
  modport sink (input valid, cell_value, cursor_pos, scrolled, output ready);
endinterface

// ----- src/text_console_cell_writer_top.sv -----
// Text console cell writer.
// in_i carries one request per command: opcode (put, backspace, clear, read),
// char_code, char_attr and read_index. out_o returns one response per request:
// the cell read (zero for other opcodes), the cursor index afterwards, and a
// scroll flag. normal_attr_i is written when normal_attr_we_i is high.
// Each request is worked on to its end before the next is taken: a put writes
// the character (a tab writes TAB_WIDTH cells, an LF after a tab first writes a
// space), CR and LF move the cursor, a clear sweeps every cell and a read waits
// for the registered read data. Any scroll is a copy sweep through every cell.
// Backspace walks back one cell at a time over empty cells.
// The cell memory has one write and one read port, read data registered.
// After reset the memory is zeroed by a pass over every cell, during
// which in_i.ready stays low. A response waits in an output register while
// out_o.ready is low; the next request is still taken and worked on, and its
// response waits until the register is free.
`include "assert_macros.svh"

module text_console_cell_writer_top import tccw_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              normal_attr_we_i,
  input  logic [ATTR_W-1:0] normal_attr_i,
  tccw_in_if.sink           in_i,
  tccw_out_if.source        out_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int IW    = $clog2(CELLS);
  localparam int COLW  = $clog2(COLUMNS);
  localparam int ROWW  = $clog2(ROWS);
  localparam int CNTW  = $clog2(TAB_WIDTH + 1);
  localparam logic [IW-1:0] LastBase = IW'((ROWS - 1) * COLUMNS);
  localparam logic [IW-1:0] CopyTop  = IW'(CELLS - COLUMNS);
  localparam logic [IW-1:0] LastCell = IW'(CELLS - 1);

  // cell memory
  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  state_e            state_q, state_d, ret_q, ret_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [COLW-1:0]   col_q, col_d;
  logic [ROWW-1:0]   row_q, row_d;
  logic              after_tab_q, after_tab_d;
  logic              scrolled_q, scrolled_d;
  logic [ATTR_W-1:0] normal_attr_q;
  logic [IW-1:0]     sweep_q, sweep_d;
  logic              sw_wr_q, sw_wr_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              lf_q, lf_d, cr_q, cr_d;
  logic              rd_ok_q, rd_ok_d;

  logic [CELL_W-1:0] pval_q, pval_d;
  logic [CELL_W-1:0] val_q, val_d;
  logic [IW-1:0]     sw_addr_q, sw_addr_d;
  logic              sw_zero_q, sw_zero_d;
  logic [ROWW-1:0]   bs_row_q, bs_row_d;
  logic [IW-1:0]     bs_base_q, bs_base_d;

  logic              in_acc;
  logic              at_col_end, cur_at_last, row_at_last;
  logic [IW-1:0]     line_base;
  logic [CELL_W-1:0] cursor_cell, space_cell;
  state_e            after_plain;
  logic              ld_valid, ld_ready;
  result_t           result;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign at_col_end  = (col_q == COLW'(COLUMNS - 1));
  assign cur_at_last = (cur_q == LastCell);
  assign row_at_last = (row_q == ROWW'(ROWS - 1));
  assign line_base   = cur_q - IW'(col_q);
  assign cursor_cell = {normal_attr_q | BLINK_BIT, CH_SPACE};
  assign space_cell  = {in_i.char_attr, CH_SPACE};
  assign after_plain = lf_q ? ST_LINE : ST_FIN;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cur_d       = cur_q;
    col_d       = col_q;
    row_d       = row_q;
    after_tab_d = after_tab_q;
    scrolled_d  = scrolled_q;
    sweep_d     = sweep_q;
    sw_wr_d     = sw_wr_q;
    cnt_d       = cnt_q;
    lf_d        = lf_q;
    cr_d        = cr_q;
    rd_ok_d     = rd_ok_q;
    pval_d      = pval_q;
    val_d       = val_q;
    sw_addr_d   = sw_addr_q;
    sw_zero_d   = sw_zero_q;
    bs_row_d    = bs_row_q;
    bs_base_d   = bs_base_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cur_q;
    ld_valid    = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        if (sweep_q == LastCell) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          scrolled_d = 1'b0;
          val_d      = '0;
          lf_d       = 1'b0;
          cr_d       = 1'b0;
          unique case (in_i.opcode)
            OPC_PUT: begin
              case (in_i.char_code)
                CH_LF: begin
                  lf_d        = 1'b1;
                  after_tab_d = 1'b0;
                  if (after_tab_q) begin
                    cnt_d   = CNTW'(1);
                    pval_d  = space_cell;
                    state_d = ST_PLAIN;
                  end else begin
                    state_d = ST_LINE;
                  end
                end
                CH_CR: begin
                  cr_d        = 1'b1;
                  after_tab_d = 1'b0;
                  state_d     = ST_LINE;
                end
                CH_TAB: begin
                  cnt_d       = CNTW'(TAB_WIDTH);
                  pval_d      = space_cell;
                  after_tab_d = 1'b1;
                  state_d     = ST_PLAIN;
                end
                default: begin
                  cnt_d       = CNTW'(1);
                  pval_d      = {in_i.char_attr, in_i.char_code};
                  after_tab_d = 1'b0;
                  state_d     = ST_PLAIN;
                end
              endcase
            end
            OPC_BKSP: begin
              mem_we    = 1'b1;
              bs_row_d  = row_q;
              bs_base_d = line_base;
              if (cur_q == '0) begin
                state_d = ST_FIN;
              end else begin
                cur_d     = cur_q - 1'b1;
                mem_re    = 1'b1;
                mem_raddr = cur_q - 1'b1;
                if (col_q == '0) begin
                  col_d = COLW'(COLUMNS - 1);
                  row_d = row_q - 1'b1;
                end else begin
                  col_d = col_q - 1'b1;
                end
                state_d = ST_BS_CHK;
              end
            end
            OPC_CLEAR: begin
              sweep_d = '0;
              state_d = ST_CLEAR;
            end
            OPC_READ: begin
              rd_ok_d   = (int'(in_i.read_index) < CELLS);
              mem_re    = 1'b1;
              mem_raddr = IW'(in_i.read_index);
              state_d   = ST_RDW;
            end
            default: ;
          endcase
        end
      end

      ST_PLAIN: begin
        mem_we    = 1'b1;
        mem_wdata = pval_q;
        pval_d    = '0;  // tab fill after the first space
        cnt_d     = cnt_q - 1'b1;
        if (cur_at_last) begin
          ret_d      = (cnt_q == CNTW'(1)) ? after_plain : ST_PLAIN;
          state_d    = ST_SCROLL;
          sweep_d    = '0;
          sw_wr_d    = 1'b0;
          cur_d      = LastBase;
          col_d      = '0;
          row_d      = ROWW'(ROWS - 1);
          scrolled_d = 1'b1;
        end else begin
          cur_d = cur_q + 1'b1;
          if (at_col_end) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          state_d = (cnt_q == CNTW'(1)) ? after_plain : ST_PLAIN;
        end
      end

      ST_LINE: begin
        mem_we = 1'b1;
        col_d  = '0;
        if (cr_q) begin
          cur_d   = line_base;
          state_d = ST_FIN;
        end else if (row_at_last) begin
          ret_d      = ST_FIN;
          state_d    = ST_SCROLL;
          sweep_d    = '0;
          sw_wr_d    = 1'b0;
          cur_d      = LastBase;
          scrolled_d = 1'b1;
        end else begin
          cur_d   = line_base + IW'(COLUMNS);
          row_d   = row_q + 1'b1;
          state_d = ST_FIN;
        end
      end

      // copy row r+1 into row r, one cell a cycle, and zero the bottom row; each write follows its read via rdata_q
      ST_SCROLL: begin
        if (sw_wr_q) begin
          mem_we    = 1'b1;
          mem_waddr = sw_addr_q;
          mem_wdata = sw_zero_q ? '0 : rdata_q;
        end
        sw_wr_d   = 1'b1;
        sw_addr_d = sweep_q;
        if (sweep_q < CopyTop) begin
          mem_re    = 1'b1;
          mem_raddr = sweep_q + IW'(COLUMNS);
          sw_zero_d = 1'b0;
        end else begin
          sw_zero_d = 1'b1;
        end
        if (sweep_q == LastCell) begin
          state_d = ST_SCDRAIN;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      ST_SCDRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = sw_addr_q;
        mem_wdata = sw_zero_q ? '0 : rdata_q;
        sw_wr_d   = 1'b0;
        state_d   = ret_q;
      end

      ST_FIN: begin
        mem_we    = 1'b1;
        mem_wdata = cursor_cell;
        state_d   = ST_DONE;
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        if (sweep_q == LastCell) begin
          cur_d   = '0;
          col_d   = '0;
          row_d   = '0;
          state_d = ST_FIN;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      // rdata_q holds the cell under cur_q here
      ST_BS_CHK: begin
        if (cur_q != '0 && rdata_q == '0) begin
          cur_d     = cur_q - 1'b1;
          mem_re    = 1'b1;
          mem_raddr = cur_q - 1'b1;
          if (col_q == '0) begin
            col_d = COLW'(COLUMNS - 1);
            row_d = row_q - 1'b1;
          end else begin
            col_d = col_q - 1'b1;
          end
        end else begin
          state_d = ST_FIN;
          if (bs_row_q == row_q || at_col_end) begin
            // stay on the cell found
          end else if ((bs_row_q - row_q) > ROWW'(1) || rdata_q == '0) begin
            cur_d = bs_base_q - IW'(COLUMNS);
            col_d = '0;
            row_d = bs_row_q - 1'b1;
          end else if (rdata_q == {normal_attr_q, CH_SPACE}) begin
            // start of a tab: land on its space
          end else begin
            cur_d = cur_q + 1'b1;
            col_d = col_q + 1'b1;
          end
        end
      end

      ST_RDW: begin
        val_d   = rd_ok_q ? rdata_q : '0;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        ld_valid = 1'b1;
        if (ld_ready) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      ret_q         <= ST_FIN;
      cur_q         <= '0;
      col_q         <= '0;
      row_q         <= '0;
      after_tab_q   <= 1'b0;
      scrolled_q    <= 1'b0;
      normal_attr_q <= NORMAL_ATTR_RST;
      sweep_q       <= '0;
      sw_wr_q       <= 1'b0;
      cnt_q         <= '0;
      lf_q          <= 1'b0;
      cr_q          <= 1'b0;
      rd_ok_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cur_q       <= cur_d;
      col_q       <= col_d;
      row_q       <= row_d;
      after_tab_q <= after_tab_d;
      scrolled_q  <= scrolled_d;
      if (normal_attr_we_i) begin
        normal_attr_q <= normal_attr_i;
      end
      sweep_q <= sweep_d;
      sw_wr_q <= sw_wr_d;
      cnt_q   <= cnt_d;
      lf_q    <= lf_d;
      cr_q    <= cr_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pval_q    <= pval_d;
    val_q     <= val_d;
    sw_addr_q <= sw_addr_d;
    sw_zero_q <= sw_zero_d;
    bs_row_q  <= bs_row_d;
    bs_base_q <= bs_base_d;
  end

  assign result.cell_value = val_q;
  assign result.cursor_pos = IDX_W'(cur_q);
  assign result.scrolled   = scrolled_q;

  tccw_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_valid_i (ld_valid),
    .ld_ready_o (ld_ready),
    .ld_data_i  (result),
    .out_o      (out_o)
  );

  `TCCW_ASSERT(a_cur_range, int'(cur_q) < CELLS, "cursor beyond screen")
  `TCCW_ASSERT_IMPL(a_cur_coords, state_q == ST_IDLE, int'(cur_q) == int'(row_q) * COLUMNS + int'(col_q), "cursor index and row/column disagree")
  `TCCW_ASSERT_NEXT(a_read_path, in_acc && in_i.opcode == OPC_READ, state_q == ST_RDW, "read request did not go to read wait")
  `TCCW_ASSERT_IMPL(a_scroll_home, state_q == ST_SCDRAIN, cur_q == LastBase && row_q == ROWW'(ROWS - 1), "scroll left cursor off bottom row start")

endmodule

// ----- src/tccw_out_reg.sv -----
module tccw_out_reg import tccw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ld_valid_i,
  output logic       ld_ready_o,
  input  result_t    ld_data_i,
  tccw_out_if.source out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // can load when empty or when the held response leaves this cycle
  assign ld_ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (ld_valid_i && ld_ready_o) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_valid_i && ld_ready_o) begin
      data_q <= ld_data_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.cell_value = data_q.cell_value;
  assign out_o.cursor_pos = data_q.cursor_pos;
  assign out_o.scrolled   = data_q.scrolled;

endmodule
